FILE: rtl/ddpr_pkg.sv
package ddpr_pkg;

    // Field and register widths.
    localparam int SPEED_W    = 8;
    localparam int PULSE_W    = 8;
    localparam int SPAN_W     = 8;
    localparam int TUNE_W     = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Number of intermediate pulse pairs in one ramp.
    localparam int RAMP_STEPS = 10;
    localparam int CNT_W      = $clog2(RAMP_STEPS + 1);

    // Accepted speed range, in percent.
    localparam int SPEED_LIMIT = 100;
    localparam logic signed [SPEED_W-1:0] SPEED_MAX = SPEED_W'(SPEED_LIMIT);
    localparam logic signed [SPEED_W-1:0] SPEED_MIN = SPEED_W'(-SPEED_LIMIT);

    // Division by 100 as a multiply by a rounded-up reciprocal. The scaled
    // magnitude stays below 2^22, which keeps the quotient exact.
    localparam int PERCENT      = 100;
    localparam int DIV100_SHIFT = 29;
    localparam int DIV100_K     = ((1 << DIV100_SHIFT) + PERCENT - 1) / PERCENT;
    localparam int DIV100_KW    = $clog2(DIV100_K + 1);
    localparam logic [DIV100_KW-1:0] DIV100_K_V = DIV100_KW'(DIV100_K);

    // Division of a pulse difference by the ramp length, same technique.
    localparam int STEP_SHIFT = 16;
    localparam int STEP_K     = ((1 << STEP_SHIFT) + RAMP_STEPS - 1) / RAMP_STEPS;
    localparam int STEP_KW    = $clog2(STEP_K + 1);
    localparam logic [STEP_KW-1:0] STEP_K_V = STEP_KW'(STEP_K);

    // Register reset values.
    localparam logic [PULSE_W-1:0] STOP_RESET = 8'd128;
    localparam logic [SPAN_W-1:0]  SPAN_RESET = 8'd127;
    localparam logic [TUNE_W-1:0]  TUNE_RESET = 7'd100;

    // Register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STOP_PULSE    = 3'd0,
        CFG_PULSE_SPAN    = 3'd1,
        CFG_TUNE_PERCENT  = 3'd2,
        CFG_LEFT_REVERSE  = 3'd3,
        CFG_RIGHT_REVERSE = 3'd4
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_REJECT,
        S_MUL_B,
        S_MUL_C,
        S_TARGET,
        S_DELTA,
        S_EMIT
    } t_state;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic capture;
        logic mul_a;
        logic mul_b;
        logic mul_c;
        logic target;
        logic delta;
        logic emit;
        logic last;
        logic reject;
    } t_dp_cmd;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic in_range;
    } t_dp_status;

endpackage

FILE: rtl/ddpr_ctrl.sv
module ddpr_ctrl import ddpr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             w_slot_free;
    logic             w_last;

    // The output register can take a result when empty or being drained.
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_last      = (r_cnt == CNT_W'(RAMP_STEPS));
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_status.in_range ? S_MUL_B : S_REJECT;
            end
            S_REJECT: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            S_MUL_B:  n_state = S_MUL_C;
            S_MUL_C:  n_state = S_TARGET;
            S_TARGET: n_state = S_DELTA;
            S_DELTA:  n_state = S_EMIT;
            S_EMIT: begin
                if (w_slot_free && w_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath commands, step counter and output valid.
    always_comb begin
        o_cmd       = '0;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
            end
            S_CHECK: begin
                o_cmd.mul_a = 1'b1;
            end
            S_REJECT: begin
                if (w_slot_free) begin
                    o_cmd.reject = 1'b1;
                    n_out_valid  = 1'b1;
                end
            end
            S_MUL_B: begin
                o_cmd.mul_b = 1'b1;
            end
            S_MUL_C: begin
                o_cmd.mul_c = 1'b1;
            end
            S_TARGET: begin
                o_cmd.target = 1'b1;
            end
            S_DELTA: begin
                o_cmd.delta = 1'b1;
                n_cnt       = '0;
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.last  = w_last;
                    n_out_valid = 1'b1;
                    n_cnt       = r_cnt + 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: rtl/ddpr_dp.sv
module ddpr_dp import ddpr_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic signed [SPEED_W-1:0] i_left_speed,
    input  logic signed [SPEED_W-1:0] i_right_speed,
    input  t_dp_cmd                   i_cmd,
    output t_dp_status                o_status,
    output logic [PULSE_W-1:0]        o_left_pulse,
    output logic [PULSE_W-1:0]        o_right_pulse,
    output logic                      o_final_step,
    output logic                      o_rejected
);

    localparam int PROD_A_W = SPAN_W + SPEED_W;
    localparam int PROD_B_W = PROD_A_W + TUNE_W;
    localparam int PROD_C_W = PROD_B_W + DIV100_KW;
    localparam int Q_W      = PROD_C_W - DIV100_SHIFT;
    localparam int SUM_W    = Q_W + 2;
    localparam int DIFF_W   = PULSE_W + 2;
    localparam int DELTA_W  = PULSE_W + 1;
    localparam int ACC_W    = PULSE_W + 2;
    localparam int DPROD_W  = STEP_SHIFT + PULSE_W;

    // Configuration registers.
    logic [PULSE_W-1:0] r_stop_pulse;
    logic [SPAN_W-1:0]  r_pulse_span;
    logic [TUNE_W-1:0]  r_tune_percent;
    logic               r_left_reverse;
    logic               r_right_reverse;

    // Per-side lanes: index 0 is left, index 1 is right.
    logic signed [SPEED_W-1:0] r_speed  [2];
    logic [PROD_A_W-1:0]       r_prod_a [2];
    logic [PROD_B_W-1:0]       r_prod_b [2];
    logic [Q_W-1:0]            r_q      [2];
    logic [PULSE_W-1:0]        r_tgt    [2];
    logic [PULSE_W-1:0]        r_held   [2];
    logic signed [DIFF_W-1:0]  r_diff   [2];
    logic signed [DELTA_W-1:0] r_delta  [2];
    logic signed [ACC_W-1:0]   r_acc    [2];
    logic [PULSE_W-1:0]        r_out    [2];
    logic                      r_final_step;
    logic                      r_rejected;

    logic                      w_rev     [2];
    logic                      w_neg     [2];
    logic [SPEED_W-1:0]        w_mag     [2];
    logic [PROD_C_W-1:0]       w_prod_c  [2];
    logic signed [SUM_W-1:0]   w_sum     [2];
    logic [PULSE_W-1:0]        w_sat     [2];
    logic signed [DIFF_W-1:0]  w_diff    [2];
    logic [PULSE_W-1:0]        w_dmag    [2];
    logic [DPROD_W-1:0]        w_dprod   [2];
    logic [PULSE_W-1:0]        w_dq      [2];
    logic signed [DELTA_W-1:0] w_delta   [2];
    logic                      w_ok      [2];

    // Register writes; indexes without a register are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_pulse    <= STOP_RESET;
            r_pulse_span    <= SPAN_RESET;
            r_tune_percent  <= TUNE_RESET;
            r_left_reverse  <= 1'b0;
            r_right_reverse <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STOP_PULSE:    r_stop_pulse    <= i_cfg_data[PULSE_W-1:0];
                CFG_PULSE_SPAN:    r_pulse_span    <= i_cfg_data[SPAN_W-1:0];
                CFG_TUNE_PERCENT:  r_tune_percent  <= i_cfg_data[TUNE_W-1:0];
                CFG_LEFT_REVERSE:  r_left_reverse  <= i_cfg_data[0];
                CFG_RIGHT_REVERSE: r_right_reverse <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_rev[0] = r_left_reverse;
    assign w_rev[1] = r_right_reverse;

    // Lane arithmetic between the registered stages.
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            // Sign and magnitude of the speed; -128 gives 128, which fits.
            w_neg[k] = r_speed[k][SPEED_W-1];
            w_mag[k] = w_neg[k] ? (~r_speed[k] + 1'b1) : r_speed[k];
            w_ok[k]  = (r_speed[k] <= SPEED_MAX) && (r_speed[k] >= SPEED_MIN);

            // Quotient by 100 through the reciprocal.
            w_prod_c[k] = PROD_C_W'(r_prod_b[k]) * PROD_C_W'(DIV100_K_V);

            // Apply the offset to the stop pulse and saturate to the pulse range.
            if (w_neg[k] ^ w_rev[k]) begin
                w_sum[k] = $signed(SUM_W'(r_stop_pulse)) - $signed(SUM_W'(r_q[k]));
            end else begin
                w_sum[k] = $signed(SUM_W'(r_stop_pulse)) + $signed(SUM_W'(r_q[k]));
            end
            if (w_sum[k][SUM_W-1]) begin
                w_sat[k] = '0;
            end else if (|w_sum[k][SUM_W-2:PULSE_W]) begin
                w_sat[k] = '1;
            end else begin
                w_sat[k] = w_sum[k][PULSE_W-1:0];
            end
            w_diff[k] = $signed(DIFF_W'(w_sat[k])) - $signed(DIFF_W'(r_held[k]));

            // Ramp step, truncated toward zero.
            w_dmag[k]  = r_diff[k][DIFF_W-1] ? PULSE_W'(-r_diff[k]) : PULSE_W'(r_diff[k]);
            w_dprod[k] = DPROD_W'(w_dmag[k]) * DPROD_W'(STEP_K_V);
            w_dq[k]    = w_dprod[k][STEP_SHIFT+PULSE_W-1:STEP_SHIFT];
            w_delta[k] = r_diff[k][DIFF_W-1] ? -$signed(DELTA_W'(w_dq[k]))
                                             : $signed(DELTA_W'(w_dq[k]));
        end
    end

    assign o_status.in_range = w_ok[0] && w_ok[1];

    // Lane pipeline and ramp accumulator.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_speed[0] <= i_left_speed;
            r_speed[1] <= i_right_speed;
        end
        for (int k = 0; k < 2; k++) begin
            if (i_cmd.mul_a) begin
                r_prod_a[k] <= PROD_A_W'(r_pulse_span) * PROD_A_W'(w_mag[k]);
            end
            if (i_cmd.mul_b) begin
                r_prod_b[k] <= PROD_B_W'(r_prod_a[k]) * PROD_B_W'(r_tune_percent);
            end
            if (i_cmd.mul_c) begin
                r_q[k] <= w_prod_c[k][PROD_C_W-1:DIV100_SHIFT];
            end
            if (i_cmd.target) begin
                r_tgt[k]  <= w_sat[k];
                r_diff[k] <= w_diff[k];
                r_acc[k]  <= $signed(ACC_W'(r_held[k]));
            end
            if (i_cmd.delta) begin
                r_delta[k] <= w_delta[k];
            end
            if (i_cmd.emit) begin
                r_out[k] <= i_cmd.last ? r_tgt[k] : r_acc[k][PULSE_W-1:0];
                r_acc[k] <= r_acc[k] + ACC_W'(r_delta[k]);
            end else if (i_cmd.reject) begin
                r_out[k] <= r_held[k];
            end
        end
        if (i_cmd.emit) begin
            r_final_step <= i_cmd.last;
            r_rejected   <= 1'b0;
        end else if (i_cmd.reject) begin
            r_final_step <= 1'b1;
            r_rejected   <= 1'b1;
        end
    end

    // Held pulses; a new target replaces them once the ramp is set up.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held[0] <= STOP_RESET;
            r_held[1] <= STOP_RESET;
        end else if (i_cmd.target) begin
            r_held[0] <= w_sat[0];
            r_held[1] <= w_sat[1];
        end
    end

    assign o_left_pulse  = r_out[0];
    assign o_right_pulse = r_out[1];
    assign o_final_step  = r_final_step;
    assign o_rejected    = r_rejected;

endmodule

FILE: rtl/differential_drive_pwm_ramp_top.sv
// Differential-drive PWM ramp. Each request carries a signed left and right
// speed in percent; the block turns them into target PWM pulses and emits
// RAMP_STEPS intermediate pulse pairs from the held pulses toward the target,
// then the target pair with o_final_step set. A request with either speed
// outside -100..100 yields one result that repeats the held pulses with
// o_final_step and o_rejected set. One request is worked at a time: the next
// request is accepted only after the sequencer returns to idle. The sequencer
// walks the lane through its range check, the three chained multiplies of
// the pulse offset, the target and ramp-step stages, and then hands one
// result per cycle to the output register while the output is not stalled.
// The user must write registers only while the block is idle; the block
// itself does not enforce it.
module differential_drive_pwm_ramp_top import ddpr_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [SPEED_W-1:0] i_left_speed,
    input  logic signed [SPEED_W-1:0] i_right_speed,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [PULSE_W-1:0]        o_left_pulse,
    output logic [PULSE_W-1:0]        o_right_pulse,
    output logic                      o_final_step,
    output logic                      o_rejected
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Sequencer.
    ddpr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Pulse arithmetic and output register.
    ddpr_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_left_speed  (i_left_speed),
        .i_right_speed (i_right_speed),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_left_pulse  (o_left_pulse),
        .o_right_pulse (o_right_pulse),
        .o_final_step  (o_final_step),
        .o_rejected    (o_rejected)
    );

endmodule

FILE: rtl/ddpr_chk.sv
module ddpr_chk import ddpr_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [PULSE_W-1:0] o_left_pulse,
    input logic [PULSE_W-1:0] o_right_pulse,
    input logic               o_final_step,
    input logic               o_rejected
);

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // An accepted request holds off the next one.
    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a request");

    // A rejected result is always the last of its request.
    a_reject_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rejected) |-> o_final_step)
        else $error("rejected result without final step");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_left_pulse)
            && $stable(o_right_pulse) && $stable(o_final_step) && $stable(o_rejected)))
        else $error("stalled result changed");

endmodule

bind differential_drive_pwm_ramp_top ddpr_chk u_ddpr_chk (.*);

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import ddpr_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int IDLE_PCT    = 32;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_GAP   = 8;

    // One speed request and one predicted pulse pair.
    typedef struct {
        logic signed [SPEED_W-1:0] left_speed;
        logic signed [SPEED_W-1:0] right_speed;
    } t_speed_cmd;

    typedef struct {
        logic [PULSE_W-1:0] left_pulse;
        logic [PULSE_W-1:0] right_pulse;
        logic               final_step;
        logic               rejected;
    } t_pulse_pair;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic signed [SPEED_W-1:0] i_left_speed = '0;
    logic signed [SPEED_W-1:0] i_right_speed = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic [PULSE_W-1:0]        o_left_pulse;
    logic [PULSE_W-1:0]        o_right_pulse;
    logic                      o_final_step;
    logic                      o_rejected;

    // Pending requests and the pulse pairs the block should still produce.
    t_speed_cmd  speed_cmd_q[$];
    t_pulse_pair ramp_q[$];

    // Shadow copy of the registers and of the held pulses.
    int cfg_stop = int'(STOP_RESET);
    int cfg_span = int'(SPAN_RESET);
    int cfg_tune = int'(TUNE_RESET);
    int cfg_left_rev = 0;
    int cfg_right_rev = 0;
    int held_left = int'(STOP_RESET);
    int held_right = int'(STOP_RESET);

    logic        in_took = 1'b0;
    logic        calm = 1'b0;
    logic        squeeze = 1'b0;
    logic        squeeze_done = 1'b0;
    int          hold_count = 0;
    int          cycles = 0;
    int          mismatches = 0;
    int          cmds_taken = 0;
    int          cmds_refused = 0;
    int          pairs_checked = 0;
    int          settings_used = 1;
    t_speed_cmd  cmd;
    t_pulse_pair want;

    differential_drive_pwm_ramp_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_left_speed  (i_left_speed),
        .i_right_speed (i_right_speed),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_left_pulse  (o_left_pulse),
        .o_right_pulse (o_right_pulse),
        .o_final_step  (o_final_step),
        .o_rejected    (o_rejected)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Target pulse of one side: scaled offset, optional reversal, clamp to 0..255.
    function automatic int target_pulse(input int speed, input int reverse);
        int offset;
        int pulse;
        offset = (cfg_span * speed * cfg_tune) / PERCENT;
        if (reverse != 0) begin
            offset = -offset;
        end
        pulse = cfg_stop + offset;
        if (pulse < 0) begin
            pulse = 0;
        end
        if (pulse > 255) begin
            pulse = 255;
        end
        return pulse;
    endfunction

    // Queue the pulse pairs that one accepted request must produce.
    task automatic predict_ramp(input logic signed [SPEED_W-1:0] left_speed,
                                input logic signed [SPEED_W-1:0] right_speed);
        int ls;
        int rs;
        int tl;
        int tr;
        int dl;
        int dr;
        t_pulse_pair pp;
        ls = int'(left_speed);
        rs = int'(right_speed);
        if (ls > SPEED_LIMIT || ls < -SPEED_LIMIT || rs > SPEED_LIMIT || rs < -SPEED_LIMIT) begin
            pp.left_pulse  = PULSE_W'(held_left);
            pp.right_pulse = PULSE_W'(held_right);
            pp.final_step  = 1'b1;
            pp.rejected    = 1'b1;
            ramp_q.push_back(pp);
            cmds_refused++;
        end else begin
            tl = target_pulse(ls, cfg_left_rev);
            tr = target_pulse(rs, cfg_right_rev);
            dl = (tl - held_left) / RAMP_STEPS;
            dr = (tr - held_right) / RAMP_STEPS;
            pp.final_step = 1'b0;
            pp.rejected   = 1'b0;
            for (int i = 0; i < RAMP_STEPS; i++) begin
                pp.left_pulse  = PULSE_W'(held_left + dl * i);
                pp.right_pulse = PULSE_W'(held_right + dr * i);
                ramp_q.push_back(pp);
            end
            pp.left_pulse  = PULSE_W'(tl);
            pp.right_pulse = PULSE_W'(tr);
            pp.final_step  = 1'b1;
            ramp_q.push_back(pp);
            held_left  = tl;
            held_right = tr;
        end
    endtask

    task automatic check_field(input string field, input logic [PULSE_W-1:0] got,
                               input logic [PULSE_W-1:0] exp_v);
        if (got !== exp_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, got);
        end
    endtask

    // Driver: offers the next request at the falling edge once the last one was taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_took) begin
            if (speed_cmd_q.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                cmd = speed_cmd_q.pop_front();
                i_in_valid    <= 1'b1;
                i_left_speed  <= cmd.left_speed;
                i_right_speed <= cmd.right_speed;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, none while calm, and one long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_count > 0) begin
            i_out_stall <= 1'b1;
            hold_count  <= hold_count - 1;
        end else if (squeeze && !squeeze_done) begin
            i_out_stall  <= 1'b1;
            hold_count   <= HOLD_CYCLES;
            squeeze_done <= 1'b1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Monitor: checks each delivered pulse pair, then predicts for an accepted request.
    always @(posedge i_clk) begin
        in_took <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (ramp_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected pulse pair %0d/%0d, nothing expected",
                             $time, o_left_pulse, o_right_pulse);
                end else begin
                    want = ramp_q.pop_front();
                    pairs_checked++;
                    check_field("left_pulse", o_left_pulse, want.left_pulse);
                    check_field("right_pulse", o_right_pulse, want.right_pulse);
                    check_field("final_step", PULSE_W'(o_final_step),
                                PULSE_W'(want.final_step));
                    check_field("rejected", PULSE_W'(o_rejected), PULSE_W'(want.rejected));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                predict_ramp(i_left_speed, i_right_speed);
                cmds_taken++;
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d pulse pairs outstanding", $time, ramp_q.size());
            $display("[differential_drive_pwm_ramp_top] ERROR");
            $finish;
        end
    end

    task automatic queue_cmd(input int left_speed, input int right_speed);
        t_speed_cmd c;
        c.left_speed  = SPEED_W'(left_speed);
        c.right_speed = SPEED_W'(right_speed);
        speed_cmd_q.push_back(c);
    endtask

    // Wait until every request went in and every pulse pair came out, then let
    // the sequencer settle back to idle.
    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (speed_cmd_q.size() > 0 || i_in_valid || ramp_q.size() > 0);
        repeat (DRAIN_GAP) @(posedge i_clk);
        #1;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            CFG_STOP_PULSE:    cfg_stop = int'(data);
            CFG_PULSE_SPAN:    cfg_span = int'(data);
            CFG_TUNE_PERCENT:  cfg_tune = int'(data[TUNE_W-1:0]);
            CFG_LEFT_REVERSE:  cfg_left_rev = int'(data[0]);
            CFG_RIGHT_REVERSE: cfg_right_rev = int'(data[0]);
            default: ;
        endcase
        @(posedge i_clk);
        #1;
    endtask

    // Write all registers, plus one write to an unused index that must be ignored.
    task automatic load_settings(input logic [7:0] stop, input logic [7:0] span,
                                 input logic [7:0] tune, input logic [7:0] left_rev,
                                 input logic [7:0] right_rev);
        write_reg(CFG_STOP_PULSE, stop);
        write_reg(CFG_PULSE_SPAN, span);
        write_reg(CFG_TUNE_PERCENT, tune);
        write_reg(CFG_LEFT_REVERSE, left_rev);
        write_reg(CFG_RIGHT_REVERSE, right_rev);
        write_reg(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, int'(CFG_RIGHT_REVERSE) + 1)),
                  CFG_DATA_W'($urandom));
        settings_used++;
    endtask

    // Mostly legal speeds, with the limits now and then and a few of any value.
    function automatic int random_speed();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10) begin
            return ($urandom_range(1) == 1) ? SPEED_LIMIT : -SPEED_LIMIT;
        end else if (pick < 92) begin
            return int'($urandom_range(2 * SPEED_LIMIT)) - SPEED_LIMIT;
        end
        return int'($signed(SPEED_W'($urandom)));
    endfunction

    function automatic int illegal_speed();
        if ($urandom_range(1) == 1) begin
            return int'($urandom_range(127, SPEED_LIMIT + 1));
        end
        return -int'($urandom_range(128, SPEED_LIMIT + 1));
    endfunction

    function automatic logic [7:0] pick_reg(input int hi);
        case ($urandom_range(5))
            0: return 8'd0;
            1: return 8'(hi);
            default: return 8'($urandom_range(hi));
        endcase
    endfunction

    initial begin
        logic [7:0] tune;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        #1;

        // Reset settings: the speed limits, zero, sign bits and rejected requests.
        queue_cmd(0, 0);
        queue_cmd(100, 100);
        queue_cmd(-100, -100);
        queue_cmd(100, -100);
        queue_cmd(101, 0);
        queue_cmd(0, -101);
        queue_cmd(127, -128);
        queue_cmd(-128, 127);
        queue_cmd(-1, 1);
        queue_cmd(1, -1);
        wait_drained();

        // Stop at zero, full span, tune above 100, both sides reversed.
        load_settings(8'd0, 8'd255, 8'hFF, 8'hFF, 8'hFF);
        queue_cmd(100, -100);
        queue_cmd(-100, 100);
        queue_cmd(0, 0);
        queue_cmd(37, -63);
        queue_cmd(-101, 5);
        wait_drained();

        // Stop at the top with no span and no tune: every target is the stop pulse.
        load_settings(8'd255, 8'd0, 8'd0, 8'd0, 8'd0);
        queue_cmd(100, 100);
        queue_cmd(-100, -100);
        queue_cmd(55, -55);
        wait_drained();

        // Random settings per phase; one phase without idling, one with a long hold-off.
        for (int phase = 0; phase < 8; phase++) begin
            if ($urandom_range(3) == 0) begin
                tune = 8'($urandom_range(127, PERCENT + 1));
            end else begin
                tune = pick_reg(PERCENT);
            end
            tune[7] = 1'($urandom_range(1));
            load_settings(pick_reg(255), pick_reg(255), tune, 8'($urandom),
                          8'($urandom));
            calm = (phase == 2);
            for (int n = 0; n < 18; n++) begin
                case ($urandom_range(9))
                    0: queue_cmd(illegal_speed(), random_speed());
                    1: queue_cmd(random_speed(), illegal_speed());
                    default: queue_cmd(random_speed(), random_speed());
                endcase
            end
            squeeze = (phase == 5);
            wait_drained();
        end

        $display("Covered %0d speed requests (%0d out of range) under %0d register settings,",
                 cmds_taken, cmds_refused, settings_used);
        $display("checking %0d pulse pairs with %0d mismatches.", pairs_checked, mismatches);
        if (mismatches == 0) begin
            $display("[differential_drive_pwm_ramp_top] OK");
        end else begin
            $display("[differential_drive_pwm_ramp_top] ERROR");
        end
        $finish;
    end

endmodule

FILE: differential_drive_pwm_ramp_top.f
rtl/ddpr_pkg.sv
rtl/ddpr_ctrl.sv
rtl/ddpr_dp.sv
rtl/differential_drive_pwm_ramp_top.sv
rtl/ddpr_chk.sv
sim/tb_top.sv
